// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Short forms for clocked concurrent assertions, all disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
        else $error("assertion failed: invariant");

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== hdl/tapt_pkg.sv =====
// ----------------------------------------------------------------------------
// tapt_pkg
// Shared widths, constants and types of the actuator position tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package tapt_pkg;

    localparam int CMD_W  = 3;
    localparam int TIME_W = 32;
    localparam int POS_W  = 14;
    localparam int FT_W   = 20;

    localparam int POS_FULL   = 10000;
    localparam int MAX_RUN_MS = 120 * 1000;
    localparam int FT_RESET   = 60000;
    localparam int RATE       = POS_FULL + POS_FULL / 10;
    localparam int RATE_W     = 14;

    // Elapsed time times rate; the product never exceeds this 46-bit width.
    localparam int DIV_W         = TIME_W + RATE_W;
    localparam int BITS_PER_STEP = 2;
    localparam int DIV_STEPS     = DIV_W / BITS_PER_STEP;
    localparam int CNT_W         = $clog2(DIV_STEPS + 1);

    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    localparam logic [CMD_W-1:0] CMD_TICK         = 3'd0;
    localparam logic [CMD_W-1:0] CMD_START_OPEN   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_START_CLOSE  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CANCEL_OPEN  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CANCEL_CLOSE = 3'd4;

    typedef enum logic [2:0] {
        OP_TICK         = 3'd0,
        OP_START_OPEN   = 3'd1,
        OP_START_CLOSE  = 3'd2,
        OP_CANCEL_OPEN  = 3'd3,
        OP_CANCEL_CLOSE = 3'd4,
        OP_NOP          = 3'd5
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [TIME_W-1:0] now_ms;
        logic [TIME_W-1:0] run_ms;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_queue_out;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [FT_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } t_div_rsp;

endpackage

`default_nettype wire

// ===== hdl/timed_actuator_position_tracker_core.sv =====
// ----------------------------------------------------------------------------
// timed_actuator_position_tracker_core
// Path: a tick with a drive running goes through execute, multiply, divider
// start, the 23-step divider, position and done; a tick with both drives off
// skips to position; other items go to done. The back end holds one at a time.
// Reset: synchronous, active low; drives off, position and times zero,
// full travel 60000 ms, input queue and result slot empty.
// ----------------------------------------------------------------------------
`default_nettype none

// The front end takes items whenever its two-entry queue has room, so the
// source can run ahead of the back end by two items. The back end reads one
// item at a time, updates the drive state and places the result in a single
// output slot. The next item starts while that result still waits to be
// popped; it only stalls at its very end if the slot is still occupied.
//
// A tick with either drive running multiplies the elapsed time by 11000 and
// divides the product by the full-travel time in a single iterative divider;
// the quotient is the distance travelled, clamped to the range of position.
// Stop times are then compared against the new time stamp.
module timed_actuator_position_tracker_core
    import tapt_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // Input item channel
    input  wire logic              push,
    output logic                   full,
    input  wire logic [CMD_W-1:0]  i_command,
    input  wire logic [TIME_W-1:0] i_now_ms,
    input  wire logic [TIME_W-1:0] i_run_ms,
    // Result item channel
    output logic                   empty,
    input  wire logic              pop,
    output logic                   o_open_drive,
    output logic                   o_close_drive,
    output logic [POS_W-1:0]       o_position,
    // Full-travel register write
    input  wire logic              i_cfg_we,
    input  wire logic [FT_W-1:0]   i_cfg_wdata
);

    t_queue_out queue;
    logic       take;

    // Decode and buffer incoming items.
    tapt_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .push      (push),
        .full      (full),
        .i_command (i_command),
        .i_now_ms  (i_now_ms),
        .i_run_ms  (i_run_ms),
        .o_queue   (queue),
        .i_take    (take)
    );

    // Execute commands, track position and present results.
    tapt_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_queue       (queue),
        .o_take        (take),
        .empty         (empty),
        .pop           (pop),
        .o_open_drive  (o_open_drive),
        .o_close_drive (o_close_drive),
        .o_position    (o_position)
    );

endmodule

`default_nettype wire

// ===== hdl/tapt_front.sv =====
// ----------------------------------------------------------------------------
// tapt_front
// Accepts input items, decodes the command and holds them in a short queue.
// ----------------------------------------------------------------------------
`default_nettype none

module tapt_front
    import tapt_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire logic [CMD_W-1:0]  i_command,
    input  wire logic [TIME_W-1:0] i_now_ms,
    input  wire logic [TIME_W-1:0] i_run_ms,
    output t_queue_out             o_queue,
    input  wire logic              i_take
);

    t_item             r_entry [QDEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_count;
    t_op               op_dec;
    logic              do_push;
    logic              do_take;

    always_comb begin
        unique case (i_command)
            CMD_TICK:         op_dec = OP_TICK;
            CMD_START_OPEN:   op_dec = OP_START_OPEN;
            CMD_START_CLOSE:  op_dec = OP_START_CLOSE;
            CMD_CANCEL_OPEN:  op_dec = OP_CANCEL_OPEN;
            CMD_CANCEL_CLOSE: op_dec = OP_CANCEL_CLOSE;
            default:          op_dec = OP_NOP;
        endcase
    end

    assign full    = (r_count == QCNT_W'(QDEPTH));
    assign do_push = push && !full;
    assign do_take = i_take && (r_count != '0);

    assign o_queue.valid = (r_count != '0);
    assign o_queue.item  = r_entry[r_rptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wptr] <= '{op: op_dec, now_ms: i_now_ms, run_ms: i_run_ms};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_take) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({do_push, do_take})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hdl/tapt_div.sv =====
// ----------------------------------------------------------------------------
// tapt_div
// Restoring divider, two quotient bits per cycle; a zero divisor gives all ones.
// ----------------------------------------------------------------------------
`default_nettype none

module tapt_div
    import tapt_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0] r_work;
    logic [FT_W:0]    r_rem;
    logic [FT_W-1:0]  r_div;
    logic [DIV_W-1:0] n_work;
    logic [FT_W:0]    n_rem;

    always_comb begin
        logic [FT_W:0]    rem;
        logic [DIV_W-1:0] work;
        logic [FT_W:0]    trial;
        rem  = r_rem;
        work = r_work;
        for (int b = 0; b < BITS_PER_STEP; b++) begin
            trial = {rem[FT_W-1:0], work[DIV_W-1]};
            work  = {work[DIV_W-2:0], 1'b0};
            if (trial >= {1'b0, r_div}) begin
                rem     = trial - {1'b0, r_div};
                work[0] = 1'b1;
            end else begin
                rem = trial;
            end
        end
        n_work = work;
        n_rem  = rem;
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_work <= i_req.dividend;
            r_rem  <= '0;
            r_div  <= i_req.divisor;
        end else if (r_busy) begin
            r_work <= n_work;
            r_rem  <= n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_work;

endmodule

`default_nettype wire

// ===== hdl/tapt_back.sv =====
// ----------------------------------------------------------------------------
// tapt_back
// Carries out queued commands on the drive state and holds the result item.
// ----------------------------------------------------------------------------
`default_nettype none

module tapt_back
    import tapt_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [FT_W-1:0]  i_cfg_wdata,
    input  wire t_queue_out       i_queue,
    output logic                  o_take,
    output logic                  empty,
    input  wire logic             pop,
    output logic                  o_open_drive,
    output logic                  o_close_drive,
    output logic [POS_W-1:0]      o_position
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_EXEC   = 7'b0000010,
        S_MUL    = 7'b0000100,
        S_DSTART = 7'b0001000,
        S_DWAIT  = 7'b0010000,
        S_POS    = 7'b0100000,
        S_DONE   = 7'b1000000
    } t_state;

    localparam logic [RATE_W-1:0] RATE_C    = RATE_W'(RATE);
    localparam logic [DIV_W-1:0]  FULL_Q    = DIV_W'(POS_FULL);
    localparam logic [POS_W:0]    FULL_SUM  = (POS_W + 1)'(POS_FULL);
    localparam logic [TIME_W-1:0] MAX_RUN_C = TIME_W'(MAX_RUN_MS);

    t_state            r_state;
    t_state            n_state;
    t_item             r_item;
    logic [FT_W-1:0]   r_ft;
    logic [TIME_W-1:0] r_time_now;
    logic              r_open_act;
    logic              r_close_act;
    logic [TIME_W-1:0] r_open_stop;
    logic [TIME_W-1:0] r_close_stop;
    logic [POS_W-1:0]  r_start_pos;
    logic [TIME_W-1:0] r_start_time;
    logic [POS_W-1:0]  r_cur_pos;
    logic              r_move;
    logic [TIME_W-1:0] r_elapsed;
    logic [DIV_W-1:0]  r_prod;
    logic              r_out_valid;
    logic              out_free;
    logic [TIME_W-1:0] run_len;
    logic [TIME_W-1:0] ft_ext;
    logic [POS_W-1:0]  new_pos;
    logic [POS_W:0]    open_sum;
    t_div_req          div_req;
    t_div_rsp          div_rsp;

    tapt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign div_req.start    = (r_state == S_DSTART);
    assign div_req.dividend = r_prod;
    assign div_req.divisor  = r_ft;

    assign out_free = !r_out_valid || pop;
    assign o_take   = (r_state == S_IDLE) && i_queue.valid;
    assign empty    = !r_out_valid;
    assign ft_ext   = TIME_W'(r_ft);

    // Run length: zero asks for full travel; limited to full travel and the cap.
    always_comb begin
        logic [TIME_W-1:0] d;
        d = (r_item.run_ms == '0) ? ft_ext : r_item.run_ms;
        if (d > ft_ext) begin
            d = ft_ext;
        end
        if (d > MAX_RUN_C) begin
            d = MAX_RUN_C;
        end
        run_len = d;
    end

    // Dead-reckoned position from the quotient of the divider.
    always_comb begin
        open_sum = {1'b0, r_start_pos} + {1'b0, div_rsp.quotient[POS_W-1:0]};
        new_pos  = r_cur_pos;
        if (r_open_act) begin
            if (div_rsp.quotient >= FULL_Q || open_sum > FULL_SUM) begin
                new_pos = POS_W'(POS_FULL);
            end else begin
                new_pos = open_sum[POS_W-1:0];
            end
        end else if (r_close_act) begin
            if (div_rsp.quotient >= DIV_W'(r_start_pos)) begin
                new_pos = '0;
            end else begin
                new_pos = r_start_pos - div_rsp.quotient[POS_W-1:0];
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_queue.valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (r_item.op == OP_TICK) begin
                    n_state = (r_open_act || r_close_act) ? S_MUL : S_POS;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_MUL:    n_state = S_DSTART;
            S_DSTART: n_state = S_DWAIT;
            S_DWAIT: begin
                if (div_rsp.done) begin
                    n_state = S_POS;
                end
            end
            S_POS: n_state = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_item <= i_queue.item;
        end
        if (r_state == S_EXEC) begin
            r_elapsed <= r_item.now_ms - r_start_time;
        end
        if (r_state == S_MUL) begin
            r_prod <= DIV_W'(r_elapsed) * DIV_W'(RATE_C);
        end
        if (r_state == S_DONE && out_free) begin
            o_open_drive  <= r_open_act;
            o_close_drive <= r_close_act;
            o_position    <= r_cur_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_ft         <= FT_W'(FT_RESET);
            r_time_now   <= '0;
            r_open_act   <= 1'b0;
            r_close_act  <= 1'b0;
            r_open_stop  <= '0;
            r_close_stop <= '0;
            r_start_pos  <= '0;
            r_start_time <= '0;
            r_cur_pos    <= '0;
            r_move       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_ft <= i_cfg_wdata;
            end
            if (r_state == S_EXEC) begin
                case (r_item.op)
                    OP_TICK: begin
                        r_time_now <= r_item.now_ms;
                        r_move     <= r_open_act || r_close_act;
                    end
                    OP_START_OPEN: begin
                        r_open_stop  <= r_time_now + run_len;
                        r_open_act   <= 1'b1;
                        r_start_pos  <= r_cur_pos;
                        r_start_time <= r_time_now;
                        r_close_act  <= 1'b0;
                        r_close_stop <= '0;
                    end
                    OP_START_CLOSE: begin
                        r_close_stop <= r_time_now + run_len;
                        r_close_act  <= 1'b1;
                        r_start_pos  <= r_cur_pos;
                        r_start_time <= r_time_now;
                        r_open_act   <= 1'b0;
                        r_open_stop  <= '0;
                    end
                    OP_CANCEL_OPEN: begin
                        r_open_act  <= 1'b0;
                        r_open_stop <= '0;
                    end
                    OP_CANCEL_CLOSE: begin
                        r_close_act  <= 1'b0;
                        r_close_stop <= '0;
                    end
                    default: begin
                    end
                endcase
            end
            if (r_state == S_POS) begin
                if (r_move) begin
                    r_cur_pos <= new_pos;
                end
                if (r_time_now >= r_open_stop) begin
                    r_open_act  <= 1'b0;
                    r_open_stop <= '0;
                end
                if (r_time_now >= r_close_stop) begin
                    r_close_act  <= 1'b0;
                    r_close_stop <= '0;
                end
            end
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/tapt_checker.sv =====
// ----------------------------------------------------------------------------
// tapt_checker
// Port-level checks of the tracker, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module tapt_checker
    import tapt_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              push,
    input wire logic              full,
    input wire logic              empty,
    input wire logic              pop,
    input wire logic              o_open_drive,
    input wire logic              o_close_drive,
    input wire logic [POS_W-1:0]  o_position
);

    // The two drives are never reported on together.
    `ASSERT_IMPL(a_drives_exclusive, i_clk, i_rst_n, !empty, !(o_open_drive && o_close_drive))

    // The reported position never leaves the travel range.
    `ASSERT_IMPL(a_position_range, i_clk, i_rst_n, !empty, o_position <= POS_W'(POS_FULL))

    // The queue can only fill up after an item was pushed.
    `ASSERT_IMPL(a_full_needs_push, i_clk, i_rst_n, $rose(full), $past(push))

    // A waiting result holds until it is popped.
    `ASSERT_NEXT(a_result_holds, i_clk, i_rst_n, !empty && !pop, !empty && $stable(o_position))

endmodule

bind timed_actuator_position_tracker_core tapt_checker u_tapt_checker (.*);

`default_nettype wire

// ===== verif/timed_actuator_position_tracker_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timed_actuator_position_tracker_checker
// Watches the item, result and full-travel channels of the tracker core. It
// keeps its own drive and position state, works out the status that each
// accepted item should return, and compares every popped result with it.
// ----------------------------------------------------------------------------

module timed_actuator_position_tracker_checker
    import tapt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic              i_full,
    input  logic [CMD_W-1:0]  i_command,
    input  logic [TIME_W-1:0] i_now_ms,
    input  logic [TIME_W-1:0] i_run_ms,
    input  logic              i_empty,
    input  logic              i_pop,
    input  logic              i_open_drive,
    input  logic              i_close_drive,
    input  logic [POS_W-1:0]  i_position,
    input  logic              i_cfg_we,
    input  logic [FT_W-1:0]   i_cfg_wdata,
    output int                o_fail_count,
    output int                o_outstanding
);

    localparam int PROD_W = 48;

    typedef struct packed {
        logic             open_drive;
        logic             close_drive;
        logic [POS_W-1:0] position;
    } t_drive_status;

    t_drive_status expected_status_q[$];
    int            failures;

    // Tracker state as the block should hold it.
    logic [FT_W-1:0]   trk_full_travel;
    logic [TIME_W-1:0] trk_time;
    logic              trk_open_on;
    logic              trk_close_on;
    logic [TIME_W-1:0] trk_open_stop;
    logic [TIME_W-1:0] trk_close_stop;
    logic [POS_W-1:0]  trk_start_pos;
    logic [TIME_W-1:0] trk_start_time;
    logic [POS_W-1:0]  trk_pos;

    // Distance covered since the run began; a zero full travel saturates.
    function automatic logic [PROD_W-1:0] distance_travelled();
        logic [TIME_W-1:0] elapsed;
        logic [PROD_W-1:0] product;
        elapsed = trk_time - trk_start_time;
        product = PROD_W'(elapsed) * PROD_W'(RATE);
        if (trk_full_travel == '0) begin
            return '1;
        end
        return product / PROD_W'(trk_full_travel);
    endfunction

    function automatic logic [TIME_W-1:0] allowed_run(input logic [TIME_W-1:0] requested);
        logic [TIME_W-1:0] run;
        run = requested;
        if (run == '0) begin
            run = TIME_W'(trk_full_travel);
        end
        if (run > TIME_W'(trk_full_travel)) begin
            run = TIME_W'(trk_full_travel);
        end
        if (run > TIME_W'(MAX_RUN_MS)) begin
            run = TIME_W'(MAX_RUN_MS);
        end
        return run;
    endfunction

    function automatic t_drive_status predict_status(input logic [CMD_W-1:0] cmd,
                                                     input logic [TIME_W-1:0] now,
                                                     input logic [TIME_W-1:0] dur);
        logic [PROD_W-1:0] moved;
        logic [PROD_W:0]   pos;
        t_drive_status     status;
        case (cmd)
            CMD_TICK: begin
                trk_time = now;
                if (trk_open_on) begin
                    moved = distance_travelled();
                    if (moved >= PROD_W'(POS_FULL)) begin
                        pos = (PROD_W + 1)'(POS_FULL);
                    end else begin
                        pos = {1'b0, moved} + (PROD_W + 1)'(trk_start_pos);
                    end
                    if (pos > (PROD_W + 1)'(POS_FULL)) begin
                        pos = (PROD_W + 1)'(POS_FULL);
                    end
                    trk_pos = pos[POS_W-1:0];
                end else if (trk_close_on) begin
                    moved = distance_travelled();
                    if (moved >= PROD_W'(trk_start_pos)) begin
                        pos = '0;
                    end else begin
                        pos = (PROD_W + 1)'(trk_start_pos) - {1'b0, moved};
                    end
                    trk_pos = pos[POS_W-1:0];
                end
                if (trk_time >= trk_open_stop) begin
                    trk_open_on   = 1'b0;
                    trk_open_stop = '0;
                end
                if (trk_time >= trk_close_stop) begin
                    trk_close_on   = 1'b0;
                    trk_close_stop = '0;
                end
            end
            CMD_START_OPEN: begin
                trk_open_stop  = trk_time + allowed_run(dur);
                trk_open_on    = 1'b1;
                trk_start_pos  = trk_pos;
                trk_start_time = trk_time;
                trk_close_on   = 1'b0;
                trk_close_stop = '0;
            end
            CMD_START_CLOSE: begin
                trk_close_stop = trk_time + allowed_run(dur);
                trk_close_on   = 1'b1;
                trk_start_pos  = trk_pos;
                trk_start_time = trk_time;
                trk_open_on    = 1'b0;
                trk_open_stop  = '0;
            end
            CMD_CANCEL_OPEN: begin
                trk_open_on   = 1'b0;
                trk_open_stop = '0;
            end
            CMD_CANCEL_CLOSE: begin
                trk_close_on   = 1'b0;
                trk_close_stop = '0;
            end
            default: begin
            end
        endcase
        status.open_drive  = trk_open_on;
        status.close_drive = trk_close_on;
        status.position    = trk_pos;
        return status;
    endfunction

    function automatic void check_field(input string name, input int unsigned expected_v,
                                        input int unsigned actual_v);
        if (expected_v != actual_v) begin
            failures++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, name, expected_v, actual_v);
        end
    endfunction

    always @(posedge i_clk) begin
        t_drive_status oldest;
        if (!i_rst_n) begin
            trk_full_travel = FT_W'(FT_RESET);
            trk_time        = '0;
            trk_open_on     = 1'b0;
            trk_close_on    = 1'b0;
            trk_open_stop   = '0;
            trk_close_stop  = '0;
            trk_start_pos   = '0;
            trk_start_time  = '0;
            trk_pos         = '0;
            expected_status_q.delete();
        end else begin
            if (i_cfg_we) begin
                trk_full_travel = i_cfg_wdata;
            end
            // The result popped here can only belong to an item taken earlier.
            if (i_pop && !i_empty) begin
                if (expected_status_q.size() == 0) begin
                    failures++;
                    $display("%0t ns: result with no item waiting, actual %0d %0d %0d",
                             $time, i_open_drive, i_close_drive, i_position);
                end else begin
                    oldest = expected_status_q.pop_front();
                    check_field("open_drive", oldest.open_drive, i_open_drive);
                    check_field("close_drive", oldest.close_drive, i_close_drive);
                    check_field("position", oldest.position, i_position);
                end
            end
            if (i_push && !i_full) begin
                expected_status_q.push_back(predict_status(i_command, i_now_ms, i_run_ms));
            end
        end
        o_outstanding <= expected_status_q.size();
        o_fail_count  <= failures;
    end

    initial begin
        failures      = 0;
        o_fail_count  = 0;
        o_outstanding = 0;
    end

endmodule

// ===== verif/tb_timed_actuator_position_tracker_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_timed_actuator_position_tracker_core
// Drives open, close, cancel and tick items into the tracker core under
// several full-travel settings, with random gaps on both channels, and lets
// a separate checker predict and compare every result before the verdict.
// ----------------------------------------------------------------------------

module tb_timed_actuator_position_tracker_core;
    import tapt_pkg::*;

    // Command codes that the block treats as no operation.
    localparam logic [CMD_W-1:0] CMD_UNUSED_FIRST = 3'd5;
    localparam logic [CMD_W-1:0] CMD_UNUSED_LAST  = 3'd7;
    localparam logic [FT_W-1:0]  FT_MAX           = {FT_W{1'b1}};
    localparam int               PHASES           = 8;
    localparam int               ITEMS_PER_PHASE  = 170;
    localparam int               HOLD_OFF_CYCLES  = 250;
    // This settling time comfortably covers a moving tick.
    localparam int               SETTLE_CYCLES    = 40;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              push          = 1'b0;
    logic              full;
    logic [CMD_W-1:0]  i_command     = '0;
    logic [TIME_W-1:0] i_now_ms      = '0;
    logic [TIME_W-1:0] i_run_ms      = '0;
    logic              empty;
    logic              pop           = 1'b0;
    logic              o_open_drive;
    logic              o_close_drive;
    logic [POS_W-1:0]  o_position;
    logic              i_cfg_we      = 1'b0;
    logic [FT_W-1:0]   i_cfg_wdata   = '0;

    int fail_count;
    int outstanding;

    // Stimulus bookkeeping: the time stamp of the last tick and the full
    // travel currently programmed, so that random ticks advance sensibly.
    logic [TIME_W-1:0] stamp        = '0;
    logic [FT_W-1:0]   ft_now       = FT_W'(FT_RESET);
    logic              idle_on      = 1'b1;
    logic              hold_request = 1'b0;
    int                items_sent   = 0;
    int                settings_used = 0;
    logic [FT_W-1:0]   ft_plan [PHASES];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    timed_actuator_position_tracker_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_command     (i_command),
        .i_now_ms      (i_now_ms),
        .i_run_ms      (i_run_ms),
        .empty         (empty),
        .pop           (pop),
        .o_open_drive  (o_open_drive),
        .o_close_drive (o_close_drive),
        .o_position    (o_position),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    timed_actuator_position_tracker_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_full        (full),
        .i_command     (i_command),
        .i_now_ms      (i_now_ms),
        .i_run_ms      (i_run_ms),
        .i_empty       (empty),
        .i_pop         (pop),
        .i_open_drive  (o_open_drive),
        .i_close_drive (o_close_drive),
        .i_position    (o_position),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    // Offers one item, taken only if the queue has room; returns once full is low.
    // Push stays high afterwards, so back-to-back items only change the
    // fields; an optional idle cycle lowers push first.
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [TIME_W-1:0] now,
                             input logic [TIME_W-1:0] dur);
        if (idle_on && $urandom_range(99) < 13) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push      <= 1'b1;
        i_command <= cmd;
        i_now_ms  <= now;
        i_run_ms  <= dur;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        if (cmd == CMD_TICK) begin
            stamp = now;
        end
        items_sent++;
    endtask

    // Stops offering items until every expected result has been popped. The
    // first edge lets the checker's count catch up with the last item taken.
    task automatic drain_results();
        push <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    // The register is only written once the block has nothing in flight.
    task automatic write_full_travel(input logic [FT_W-1:0] value);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        ft_now = value;
        settings_used++;
    endtask

    // Random items mostly follow the life of a real actuator: ticks that move
    // forward by a fraction of a run, starts with a spread of durations, and
    // cancels. A few ticks jump anywhere in the 32-bit range, and a few items
    // carry the unused command codes.
    task automatic send_random_item();
        int                pick;
        int                dur_pick;
        logic [CMD_W-1:0]  cmd;
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] dur;
        logic [TIME_W-1:0] span;
        if (ft_now == '0) begin
            span = 1000;
        end else if (ft_now > MAX_RUN_MS) begin
            span = MAX_RUN_MS;
        end else begin
            span = TIME_W'(ft_now);
        end
        pick = $urandom_range(99);
        now  = $urandom();
        dur  = $urandom();
        if (pick < 45) begin
            cmd = CMD_TICK;
            now = stamp + $urandom_range(span / 5 + 1, 1);
        end else if (pick < 49) begin
            cmd = CMD_TICK;
        end else if (pick < 51) begin
            cmd = CMD_TICK;
            now = stamp;
        end else if (pick < 81) begin
            cmd      = (pick < 66) ? CMD_START_OPEN : CMD_START_CLOSE;
            dur_pick = $urandom_range(9);
            case (dur_pick)
                0, 1:    dur = '0;
                2, 3, 4, 5: dur = $urandom_range(span, 1);
                6:       dur = span + $urandom_range(3);
                7:       dur = ft_now + $urandom_range(100000);
                8:       dur = MAX_RUN_MS - 1 + $urandom_range(2);
                default: dur = $urandom();
            endcase
        end else if (pick < 88) begin
            cmd = CMD_CANCEL_OPEN;
        end else if (pick < 95) begin
            cmd = CMD_CANCEL_CLOSE;
        end else begin
            cmd = CMD_W'($urandom_range(CMD_UNUSED_LAST, CMD_UNUSED_FIRST));
        end
        send_item(cmd, now, dur);
    endtask

    // Result side: pops at random, or every cycle in the stretch without
    // idling, and holds off for a long count of cycles when asked to.
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else if (idle_on) begin
                pop <= ($urandom_range(99) >= 13);
            end else begin
                pop <= 1'b1;
            end
        end
    end

    initial begin
        ft_plan[0] = 20'd1;
        ft_plan[1] = 20'd1000;
        ft_plan[2] = FT_W'(FT_RESET);
        ft_plan[3] = FT_MAX;
        ft_plan[4] = 20'd1000000;
        ft_plan[5] = FT_W'($urandom_range(1000000, 2));
        ft_plan[6] = '0;
        ft_plan[7] = FT_W'($urandom_range(FT_MAX, 0));

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at the reset full travel of 60000 ms. A full run
        // overshoots and clamps at fully open, then a close run comes back.
        send_item(CMD_TICK, '0, '1);
        send_item(CMD_START_OPEN, '1, '0);
        send_item(CMD_TICK, 32'd30000, '0);
        send_item(CMD_TICK, 32'd60000, '0);
        send_item(CMD_START_CLOSE, '0, '1);
        send_item(CMD_TICK, 32'd90000, '1);
        // A start in the opposite direction cancels the running drive.
        send_item(CMD_START_OPEN, '0, 32'd1000);
        send_item(CMD_TICK, 32'd91000, '0);
        send_item(CMD_START_CLOSE, '0, 32'd200000);
        send_item(CMD_CANCEL_CLOSE, '1, '1);
        send_item(CMD_CANCEL_OPEN, '0, '0);
        // Unused codes must leave the state alone.
        send_item(CMD_UNUSED_FIRST, '1, '1);
        send_item(CMD_UNUSED_LAST, '0, '0);
        send_item(CMD_UNUSED_FIRST + 1'b1, 32'h5555_5555, 32'hAAAA_AAAA);
        // A stop time that wraps past the top of the time range stops the
        // drive at the very next tick; later ticks wrap the elapsed time.
        send_item(CMD_TICK, 32'hFFFF_FFF0, '0);
        send_item(CMD_START_OPEN, '0, 32'd100);
        send_item(CMD_TICK, 32'hFFFF_FFF5, '0);
        send_item(CMD_START_CLOSE, '0, '0);
        send_item(CMD_TICK, 32'h0000_1000, '0);
        send_item(CMD_TICK, '0, '0);

        // With a zero full travel the divider saturates and runs have no length.
        write_full_travel('0);
        send_item(CMD_START_OPEN, '0, 32'd5);
        send_item(CMD_TICK, '0, '0);
        send_item(CMD_START_CLOSE, '0, '0);
        send_item(CMD_TICK, 32'd1, '0);

        // The widest register value; runs are then limited to two minutes.
        write_full_travel(FT_MAX);
        send_item(CMD_START_OPEN, '0, MAX_RUN_MS + 1);
        send_item(CMD_TICK, 32'd1 + MAX_RUN_MS, '0);

        for (int phase = 0; phase < PHASES; phase++) begin
            write_full_travel(ft_plan[phase]);
            // One phase runs without any idling on either side.
            idle_on = (phase != 2);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (phase == 1 && n == 85) begin
                    drain_results();
                end
                // The receiver stalls while items keep coming, so the input
                // queue and result slot fill up and full is raised.
                if (phase == 3 && n == 40) begin
                    hold_request = 1'b1;
                end
                send_random_item();
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Covered %0d items over %0d full-travel settings, zero and widest included.",
                 items_sent, settings_used);
        $display("Both channels idled at random, with a stall-free phase and a long pop hold-off.");
        if (fail_count == 0) begin
            $display("PASS timed_actuator_position_tracker_core");
        end else begin
            $display("FAIL timed_actuator_position_tracker_core");
        end
        $finish;
    end

    // A correct run needs well under a millisecond of simulated time.
    initial begin
        #5_000_000;
        $display("Timed out with %0d results still expected.", outstanding);
        $display("FAIL timed_actuator_position_tracker_core");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/tapt_pkg.sv
hdl/tapt_front.sv
hdl/tapt_div.sv
hdl/tapt_back.sv
hdl/timed_actuator_position_tracker_core.sv
hdl/tapt_checker.sv
verif/timed_actuator_position_tracker_checker.sv
verif/tb_timed_actuator_position_tracker_core.sv
